### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the chunked body decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low)
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/hbcd_pkg.sv
// ----------------------------------------------------------------------------
// hbcd_pkg
// Shared types and codes of the HTTP body chunked decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hbcd_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    // Configuration register indexes
    localparam logic CFG_CHUNKED_MODE   = 1'b0;
    localparam logic CFG_CONTENT_LENGTH = 1'b1;

    // One result item plus its valid flag
    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] data;
        logic       body_end;
    } t_result;

endpackage

`default_nettype wire

### rtl/hbcd_core.sv
// ----------------------------------------------------------------------------
// hbcd_core
// Decode state machine: one registered byte per cycle while i_fire is high, counters for chunk
// size and body length, combinational result for the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hbcd_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_chunked_mode,
    input  wire logic [31:0]       i_content_length,
    output hbcd_pkg::t_result      o_res
);

    localparam int CMP_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    typedef enum logic [2:0] {
        PH_SIZE   = 3'd0,
        PH_EXT    = 3'd1,
        PH_EXT_CR = 3'd2,
        PH_DATA   = 3'd3,
        PH_TAIL1  = 3'd4,
        PH_TAIL2  = 3'd5,
        PH_DONE   = 3'd6
    } t_phase;

    // Hex digit decode: bit 4 flags a valid digit
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_chunk, n_chunk;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_digit, n_digit;

    logic [4:0]             hex;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [CMP_W-1:0]       count_ext;
    logic [CMP_W-1:0]       inc_ext;
    logic [CMP_W-1:0]       len_ext;
    hbcd_pkg::t_result      res;

    assign hex       = hex_decode(i_byte);
    assign count_inc = r_count + 1'b1;
    assign count_ext = CMP_W'(r_count);
    assign inc_ext   = CMP_W'(count_inc);
    assign len_ext   = CMP_W'(i_content_length);

    // Next state and result for the current byte
    always_comb begin
        n_phase = r_phase;
        n_chunk = r_chunk;
        n_count = r_count;
        n_digit = r_digit;
        res     = '{valid: 1'b0, kind: hbcd_pkg::KIND_DATA, data: 8'd0, body_end: 1'b0};

        if (!i_chunked_mode) begin
            // Length mode: forward until content length is reached
            priority if (r_phase == PH_DONE || count_ext >= len_ext || (&r_count)) begin
                n_phase   = PH_DONE;
                res.valid = 1'b1;
                res.kind  = hbcd_pkg::KIND_ERROR;
            end else begin
                n_count       = count_inc;
                res.valid     = 1'b1;
                res.data      = i_byte;
                if (inc_ext == len_ext) begin
                    n_phase      = PH_DONE;
                    res.body_end = 1'b1;
                end
            end
        end else begin
            unique case (r_phase)
                PH_SIZE: begin
                    // Accumulate hex digits, skip leading blanks, flag a size overflow as an error
                    priority if (hex[4]) begin
                        if (r_chunk[COUNT_WIDTH-1 -: 4] != 4'd0) begin
                            n_phase   = PH_DONE;
                            res.valid = 1'b1;
                            res.kind  = hbcd_pkg::KIND_ERROR;
                        end else begin
                            n_chunk = {r_chunk[COUNT_WIDTH-5:0], hex[3:0]};
                            n_digit = 1'b1;
                        end
                    end else if (!r_digit && (i_byte == CHAR_SPACE || i_byte == CHAR_TAB)) begin
                        n_phase = PH_SIZE;
                    end else begin
                        n_phase = (i_byte == CHAR_CR) ? PH_EXT_CR : PH_EXT;
                    end
                end
                PH_EXT: begin
                    // Drop extension bytes until CR
                    if (i_byte == CHAR_CR) begin
                        n_phase = PH_EXT_CR;
                    end
                end
                PH_EXT_CR: begin
                    priority if (i_byte == CHAR_LF) begin
                        n_digit = 1'b0;
                        if (r_chunk == '0) begin
                            n_phase      = PH_DONE;
                            res.valid    = 1'b1;
                            res.kind     = hbcd_pkg::KIND_END;
                            res.body_end = 1'b1;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end else if (i_byte != CHAR_CR) begin
                        n_phase = PH_EXT;
                    end else begin
                        n_phase = PH_EXT_CR;
                    end
                end
                PH_DATA: begin
                    // Forward chunk data, count down the chunk size
                    if (r_chunk != '0) begin
                        n_chunk = r_chunk - 1'b1;
                    end
                    if (r_chunk <= COUNT_WIDTH'(1)) begin
                        n_phase = PH_TAIL1;
                    end
                    res.valid = 1'b1;
                    res.data  = i_byte;
                end
                PH_TAIL1: begin
                    n_phase = PH_TAIL2;
                end
                PH_TAIL2: begin
                    n_phase = PH_SIZE;
                    n_chunk = '0;
                    n_digit = 1'b0;
                end
                default: begin
                    n_phase   = PH_DONE;
                    res.valid = 1'b1;
                    res.kind  = hbcd_pkg::KIND_ERROR;
                end
            endcase
        end
    end

    // Hold state, advance on each processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE;
            r_chunk <= '0;
            r_count <= '0;
            r_digit <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_chunk <= n_chunk;
            r_count <= n_count;
            r_digit <= n_digit;
        end
    end

    assign o_res = res;

    `ASSERT_NEXT(a_error_ends_body, i_clk, i_rst_n,
        i_fire && res.valid && res.kind == hbcd_pkg::KIND_ERROR,
        r_phase == PH_DONE, "error result did not move phase to done")
    `ASSERT_IMP(a_data_holds_count, i_clk, i_rst_n,
        r_phase == PH_DATA, r_chunk != '0, "data phase with empty chunk count")
    `ASSERT_IMP(a_nondata_clean, i_clk, i_rst_n,
        res.valid && res.kind != hbcd_pkg::KIND_DATA,
        res.data == 8'd0 && (res.body_end == (res.kind == hbcd_pkg::KIND_END)),
        "non-data result carries data or wrong end flag")

endmodule

`default_nettype wire

### rtl/hbcd_out_reg.sv
// ----------------------------------------------------------------------------
// hbcd_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hbcd_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire hbcd_pkg::t_result i_res,
    input  wire logic              i_out_stall,
    output logic                   o_space,
    output logic                   o_out_valid,
    output logic [1:0]             o_kind,
    output logic [7:0]             o_data_byte,
    output logic                   o_body_end
);

    logic              r_valid;
    hbcd_pkg::t_result r_res;

    // Free when empty or when the held result leaves this cycle
    assign o_space = !r_valid || !i_out_stall;

    // Load a new result, or drop the held one once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res.valid;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Payload holds while stalled
    always_ff @(posedge i_clk) begin
        if (i_load && i_res.valid) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_kind      = r_res.kind;
    assign o_data_byte = r_res.data;
    assign o_body_end  = r_res.body_end;

endmodule

`default_nettype wire

### rtl/http_body_chunked_decoder_unit.sv
// Path: each accepted byte is held in the input register, then decoded
// into the result register.
// Throughput: one byte per cycle, limited only by output stall; bytes that
// produce no result (size line, trailing CR LF) still wait for room in the result register.
// Reset: synchronous active-low i_rst_n clears both pipeline valid flags,
// decode state (size-digit phase, zero counters) and config registers.
// ----------------------------------------------------------------------------
// http_body_chunked_decoder_unit
// HTTP/1.1 request body decoder, length or chunked transfer encoding.
// ----------------------------------------------------------------------------
`default_nettype none

module http_body_chunked_decoder_unit #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // Input request channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    // Result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_data_byte,
    output logic             o_body_end
);

    logic              r_chunked_mode;
    logic [31:0]       r_content_length;
    logic              r_in_valid, n_in_valid;
    logic [7:0]        r_in_byte;
    logic              space;
    logic              move;
    hbcd_pkg::t_result res;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunked_mode   <= 1'b0;
            r_content_length <= 32'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hbcd_pkg::CFG_CHUNKED_MODE:   r_chunked_mode   <= i_cfg_data[0];
                hbcd_pkg::CFG_CONTENT_LENGTH: r_content_length <= i_cfg_data;
                default:                      r_chunked_mode   <= r_chunked_mode;
            endcase
        end
    end

    // Input register: advance when the result side has room
    assign move       = r_in_valid && space;
    assign o_in_stall = r_in_valid && !space;
    assign n_in_valid = (i_in_valid && !o_in_stall) || (r_in_valid && !move);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    hbcd_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (move),
        .i_byte           (r_in_byte),
        .i_chunked_mode   (r_chunked_mode),
        .i_content_length (r_content_length),
        .o_res            (res)
    );

    hbcd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (move),
        .i_res       (res),
        .i_out_stall (i_out_stall),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte),
        .o_body_end  (o_body_end)
    );

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Chunked body decoder testbench
// Streams request body bytes into the decoder in length mode and in chunked
// mode, predicts every result from a behavioral copy of the decode state,
// and checks each result field by field under random idle and stall gaps.
// ----------------------------------------------------------------------------

module tb;

    // Decode phases of the behavioral copy
    typedef enum logic [2:0] {
        ST_SIZE, ST_EXT, ST_EXT_CR, ST_DATA, ST_TAIL1, ST_TAIL2, ST_DONE
    } t_body_phase;

    // Ways the single body of the run is brought to its end
    typedef enum int {
        END_ZERO_CHUNK, END_NO_DIGITS, END_OVERFLOW, END_LENGTH_REACHED, END_LENGTH_SHORT
    } t_body_close;

    typedef logic [7:0] t_byte_q[$];

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_SEMI = ";";
    localparam logic [7:0] CH_ZERO = "0";
    localparam logic [7:0] CH_LA   = "a";
    localparam logic [7:0] CH_UA   = "A";
    localparam logic [7:0] CH_FILL = "z";

    // Predicts decoder results byte by byte and holds the ones still due
    class body_result_tracker;
        logic              chunked;
        logic [31:0]       content_len;
        t_body_phase       phase;
        logic [31:0]       remaining;
        logic [31:0]       body_count;
        logic              digit_seen;
        hbcd_pkg::t_result pending_results[$];
        int                errors;
        int                checked;

        function new();
            chunked     = 1'b0;
            content_len = '0;
            phase       = ST_SIZE;
            remaining   = '0;
            body_count  = '0;
            digit_seen  = 1'b0;
            errors      = 0;
            checked     = 0;
        endfunction

        function void write_reg(logic idx, logic [31:0] value);
            if (idx == hbcd_pkg::CFG_CHUNKED_MODE) begin
                chunked = value[0];
            end else begin
                content_len = value;
            end
        endfunction

        function int hex_value(logic [7:0] b);
            if (b >= "0" && b <= "9") return int'(b - "0");
            if (b >= "a" && b <= "f") return int'(b - "a") + 10;
            if (b >= "A" && b <= "F") return int'(b - "A") + 10;
            return -1;
        endfunction

        // Advance the decode state by one accepted byte
        function void note_byte(logic [7:0] b);
            hbcd_pkg::t_result r;
            int                hv;
            bit                hit;
            bit                bad;
            r       = '0;
            r.valid = 1'b1;
            hit     = 1'b0;
            bad     = 1'b0;
            if (!chunked) begin
                if (phase >= ST_DONE || body_count >= content_len || body_count == '1) begin
                    bad = 1'b1;
                end else begin
                    body_count = body_count + 1;
                    r.kind = hbcd_pkg::KIND_DATA;
                    r.data = b;
                    hit    = 1'b1;
                    if (body_count == content_len) begin
                        phase      = ST_DONE;
                        r.body_end = 1'b1;
                    end
                end
            end else begin
                case (phase)
                    ST_SIZE: begin
                        hv = hex_value(b);
                        if (hv >= 0) begin
                            if (remaining > 32'h0FFF_FFFF) begin
                                bad = 1'b1;
                            end else begin
                                remaining  = {remaining[27:0], 4'(hv)};
                                digit_seen = 1'b1;
                            end
                        end else if (!digit_seen && (b == CH_SP || b == CH_TAB)) begin
                            // skip leading blank
                        end else begin
                            phase = (b == CH_CR) ? ST_EXT_CR : ST_EXT;
                        end
                    end
                    ST_EXT: begin
                        if (b == CH_CR) phase = ST_EXT_CR;
                    end
                    ST_EXT_CR: begin
                        if (b == CH_LF) begin
                            digit_seen = 1'b0;
                            if (remaining == '0) begin
                                phase      = ST_DONE;
                                r.kind     = hbcd_pkg::KIND_END;
                                r.body_end = 1'b1;
                                hit        = 1'b1;
                            end else begin
                                phase = ST_DATA;
                            end
                        end else if (b != CH_CR) begin
                            phase = ST_EXT;
                        end
                    end
                    ST_DATA: begin
                        if (remaining != '0) remaining = remaining - 1;
                        if (remaining == '0) phase = ST_TAIL1;
                        r.kind = hbcd_pkg::KIND_DATA;
                        r.data = b;
                        hit    = 1'b1;
                    end
                    ST_TAIL1: phase = ST_TAIL2;
                    ST_TAIL2: begin
                        phase      = ST_SIZE;
                        remaining  = '0;
                        digit_seen = 1'b0;
                    end
                    default: bad = 1'b1;
                endcase
            end
            if (bad) begin
                phase  = ST_DONE;
                r.kind = hbcd_pkg::KIND_ERROR;
                hit    = 1'b1;
            end
            if (hit) pending_results.insert(pending_results.size(), r);
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_result(hbcd_pkg::t_kind kind, logic [7:0] data, logic body_end);
            hbcd_pkg::t_result want;
            checked++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result kind=%0d data=%02h end=%0b",
                         $time, kind, data, body_end);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (kind !== want.kind) begin
                $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
                errors++;
            end
            if (data !== want.data) begin
                $display("%0t: data_byte expected %02h actual %02h", $time, want.data, data);
                errors++;
            end
            if (body_end !== want.body_end) begin
                $display("%0t: body_end expected %0b actual %0b",
                         $time, want.body_end, body_end);
                errors++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_rx_byte   = '0;
    logic        i_out_stall = 1'b0;
    logic        o_cfg_ready;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic        o_body_end;

    body_result_tracker tracker;
    t_byte_q            stream;
    int                 sent = 0;

    http_body_chunked_decoder_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte),
        .o_body_end  (o_body_end)
    );

    initial forever #4 i_clk = ~i_clk;

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10) return CH_ZERO + 8'(v);
        return (upper ? CH_UA : CH_LA) + 8'(v) - 8'd10;
    endfunction

    // Append one byte to the pending stream
    function automatic void add_byte(input logic [7:0] b);
        stream = {stream, b};
    endfunction

    // Line end with an optional extension; a digitless line keeps to a non-blank separator
    function automatic void push_eol(input bit digitless);
        logic [7:0] seps[5];
        logic [7:0] c;
        seps = '{CH_SEMI, "q", CH_LF, CH_SP, CH_TAB};
        if (digitless || $urandom_range(0, 2) == 0) begin
            add_byte(seps[$urandom_range(0, digitless ? 2 : 4)]);
            repeat ($urandom_range(0, 6)) begin
                c = 8'($urandom_range(0, 255));
                add_byte(c);
                // keep a lone CR from ending the line early
                if (c == CH_CR) add_byte(CH_FILL);
            end
        end
        if ($urandom_range(0, 4) == 0) add_byte(CH_CR);
        add_byte(CH_CR);
        add_byte(CH_LF);
    endfunction

    function automatic void push_size_line(input logic [31:0] size, input bit digitless);
        int nib;
        int lead;
        bit upper;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) add_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
        end
        if (!digitless) begin
            nib = 1;
            for (int i = 1; i < 8; i++) begin
                if ((size >> (4 * i)) != 0) nib = i + 1;
            end
            lead  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10 - nib) : 0;
            upper = 1'($urandom_range(0, 1));
            repeat (lead) add_byte(CH_ZERO);
            for (int i = nib - 1; i >= 0; i--) begin
                add_byte(hex_char(4'((size >> (4 * i)) & 32'hF), upper));
            end
        end
        push_eol(digitless);
    endfunction

    // Offer one byte after a random gap and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        int g;
        g = (((sent / 100) % 5) == 2) ? 0 : pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_byte(b);
        sent++;
    endtask

    task automatic send_range(input int lo, input int hi);
        for (int i = lo; i < hi; i++) send_byte(stream[i]);
    endtask

    // Wait for every due result, then let bytes without a result clear the pipe
    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, value);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Switch to length mode for a few bytes, then back to chunked mode
    task automatic length_burst(input int n);
        logic [31:0] lim;
        drain();
        lim = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
            : tracker.body_count + n + $urandom_range(1, 1000);
        cfg_write(hbcd_pkg::CFG_CONTENT_LENGTH, lim);
        cfg_write(hbcd_pkg::CFG_CHUNKED_MODE, 32'd0);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
        drain();
        cfg_write(hbcd_pkg::CFG_CHUNKED_MODE, 32'd1);
        if ($urandom_range(0, 2) == 0) cfg_write(hbcd_pkg::CFG_CONTENT_LENGTH, 32'h0);
    endtask

    task automatic run_directed();
        cfg_write(hbcd_pkg::CFG_CONTENT_LENGTH, 32'hFFFF_FFFF);
        cfg_write(hbcd_pkg::CFG_CHUNKED_MODE, 32'd0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);
        drain();
        cfg_write(hbcd_pkg::CFG_CHUNKED_MODE, 32'd1);
        cfg_write(hbcd_pkg::CFG_CONTENT_LENGTH, 32'h0);
        // blanks, eight digits, extension with lone LF and lone CR, CR CR LF
        stream = '{CH_SP, CH_TAB, "0", "0", "0", "0", "0", "0", "0", "3",
                   CH_SEMI, CH_LF, CH_CR, "x", CH_CR, CH_CR, CH_LF,
                   8'h00, 8'hFF, CH_CR, CH_CR, CH_LF};
        send_range(0, stream.size());
        stream.delete();
    endtask

    // Well-formed chunks with random content, some cut by a length-mode burst
    task automatic run_random();
        int r;
        int size;
        int cut;
        while (sent < 1110) begin
            if ($urandom_range(0, 99) < 12) begin
                length_burst($urandom_range(1, 24));
            end else begin
                r    = $urandom_range(0, 99);
                size = (r < 70) ? $urandom_range(1, 16)
                     : (r < 95) ? $urandom_range(17, 96) : $urandom_range(97, 400);
                push_size_line(size, 1'b0);
                repeat (size + 2) add_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 9) == 0) begin
                    cut = $urandom_range(0, stream.size() - 1);
                    send_range(0, cut);
                    length_burst($urandom_range(1, 12));
                    send_range(cut, stream.size());
                end else begin
                    send_range(0, stream.size());
                end
                stream.delete();
            end
        end
    endtask

    // End the body one way, then feed bytes past the end in both modes
    task automatic run_ending();
        int k;
        case (t_body_close'($urandom_range(0, 4)))
            END_ZERO_CHUNK: push_size_line(32'h0, 1'b0);
            END_NO_DIGITS:  push_size_line(32'h0, 1'b1);
            END_OVERFLOW: begin
                add_byte(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(0, 1))));
                repeat (8) begin
                    add_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
                end
                push_eol(1'b0);
            end
            END_LENGTH_REACHED: begin
                drain();
                k = $urandom_range(1, 8);
                cfg_write(hbcd_pkg::CFG_CONTENT_LENGTH, tracker.body_count + k);
                cfg_write(hbcd_pkg::CFG_CHUNKED_MODE, 32'd0);
                repeat (k) send_byte(8'($urandom_range(0, 255)));
            end
            default: begin
                drain();
                cfg_write(hbcd_pkg::CFG_CONTENT_LENGTH,
                          $urandom_range(0, 1) ? 32'h0 : tracker.body_count);
                cfg_write(hbcd_pkg::CFG_CHUNKED_MODE, 32'd0);
            end
        endcase
        send_range(0, stream.size());
        stream.delete();
        repeat (6) send_byte(8'($urandom_range(0, 255)));
        drain();
        cfg_write(hbcd_pkg::CFG_CHUNKED_MODE, 32'(!tracker.chunked));
        repeat (6) send_byte(8'($urandom_range(0, 255)));
    endtask

    // Result side: check accepted results, stall at random, hold off once for long
    initial begin
        int  stall_left;
        int  rx_cycle;
        bit  held;
        stall_left = 0;
        rx_cycle   = 0;
        held       = 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                tracker.check_result(hbcd_pkg::t_kind'(o_kind), o_data_byte, o_body_end);
            end
            if (!held && tracker.checked >= 150 && i_in_valid) begin
                held = 1'b1;
                i_out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                rx_cycle += 300;
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
                stall_left = (((rx_cycle / 400) % 5) == 3) ? 0 : pick_gap();
            end
        end
    end

    initial begin
        tracker = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        run_ending();
        drain();
        repeat (10) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/hbcd_pkg.sv
rtl/hbcd_core.sv
rtl/hbcd_out_reg.sv
rtl/http_body_chunked_decoder_unit.sv
tb/sv/tb.sv
